// File: sv/larb_pkg.sv
// Package: shared types, constants and helpers of the lane accumulate row buffer.
`timescale 1ns / 1ps
package larb_pkg;

  localparam int ROW_COUNT  = 256;
  localparam int LANE_COUNT = 4;
  localparam int LANE_W     = 16;
  localparam int WORD_W     = 64;
  localparam int ROW_AW     = $clog2(ROW_COUNT);
  localparam int LANE_IW    = $clog2(LANE_COUNT);

  localparam logic [1:0] FUNC_LATCH  = 2'd0;
  localparam logic [1:0] FUNC_ACC    = 2'd1;
  localparam logic [1:0] FUNC_COMMIT = 2'd2;

  typedef logic [LANE_COUNT-1:0][LANE_W-1:0] lanes_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         row_addr;
    logic [1:0]         lane;
    logic               wide_mode;
    logic               first_slice;
    logic               fresh_row_valid;
    logic signed [31:0] mac_value;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] row_word;
    logic [WORD_W-1:0] buffer_word;
  } out_t;

  typedef struct packed {
    logic              rd_en;
    logic [ROW_AW-1:0] rd_addr;
    logic              wr_en;
    logic [ROW_AW-1:0] wr_addr;
  } store_req_t;

  // Lanes above LANE_COUNT read as zero.
  function automatic logic [WORD_W-1:0] pack_lanes(input lanes_t v);
    return WORD_W'(v);
  endfunction

  // Reduce a lane number modulo LANE_COUNT (one subtract suffices for counts >= 2).
  function automatic logic [LANE_IW-1:0] lane_mod(input logic [1:0] lane);
    logic [2:0] t;
    t = {1'b0, lane};
    if (t >= 3'(LANE_COUNT)) begin
      t = t - 3'(LANE_COUNT);
    end
    return LANE_IW'(t);
  endfunction

endpackage

// File: sv/lane_accumulate_row_buffer_top.sv
// Top level: lane accumulate row buffer with input stage and result register.
`timescale 1ns / 1ps
// Path: an accepted item is registered in the input stage, then in the result register
// once that register is free or drains; out_stall can hold it in the input stage.
// Throughput: one item per cycle while out_stall is low; a latch issues its row store
// read at the input transfer so the registered data meets it in the execute stage.
// Reset: clears both valid flags, the lane copies, the write buffer and the per-row
// valid bits; a row never committed reads as zero, so the store needs no clearing pass.
module lane_accumulate_row_buffer_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  larb_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output larb_pkg::out_t out_data
);

  logic                        s1_valid_r;
  larb_pkg::in_t               s1_item_r;
  logic                        out_valid_r;
  larb_pkg::out_t              out_data_r;
  logic                        fire;
  logic                        accept;
  larb_pkg::store_req_t        store_req;
  logic [larb_pkg::WORD_W-1:0] row_data;
  logic [larb_pkg::WORD_W-1:0] buffer_word;
  larb_pkg::out_t              result;

  // Advance the execute stage whenever the result register is free or drains now.
  assign fire     = s1_valid_r && (!out_valid_r || !out_stall);
  // Take a new transfer whenever the execute stage is empty or advances this edge.
  assign in_stall = s1_valid_r && !fire;
  assign accept   = in_valid && !in_stall;

  // Read the row for a latch at transfer time; commit writes the current buffer
  // when it leaves the execute stage. Row addresses arrive already in range.
  always_comb begin
    store_req.rd_en   = accept && (in_data.func == larb_pkg::FUNC_LATCH);
    store_req.rd_addr = larb_pkg::ROW_AW'(in_data.row_addr);
    store_req.wr_en   = fire && (s1_item_r.func == larb_pkg::FUNC_COMMIT);
    store_req.wr_addr = larb_pkg::ROW_AW'(s1_item_r.row_addr);
  end

  larb_row_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (store_req),
    .wr_data  (buffer_word),
    .row_data (row_data)
  );

  larb_lane_unit u_lanes (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .item        (s1_item_r),
    .row_data    (row_data),
    .result      (result),
    .buffer_word (buffer_word)
  );

  // Control: stage and result valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: hold while stalled, load on advance.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_data;
    end
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/larb_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module larb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/larb_row_store.sv
// Row store: RAM with per-row valid bits and same-edge write forwarding.
`timescale 1ns / 1ps
module larb_row_store (
  input  logic                            clk,
  input  logic                            rst_n,
  input  larb_pkg::store_req_t            req,
  input  logic [larb_pkg::WORD_W-1:0]     wr_data,
  output logic [larb_pkg::WORD_W-1:0]     row_data
);

  logic [larb_pkg::ROW_COUNT-1:0] valid_r;
  logic                           vld_q_r;
  logic                           byp_r;
  logic [larb_pkg::WORD_W-1:0]    byp_data_r;
  logic [larb_pkg::WORD_W-1:0]    ram_q;

  larb_ram #(
    .WIDTH (larb_pkg::WORD_W),
    .DEPTH (larb_pkg::ROW_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .wr_addr (req.wr_addr),
    .wr_data (wr_data),
    .rd_en   (req.rd_en),
    .rd_addr (req.rd_addr),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_q_r <= 1'b0;
      byp_r   <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        vld_q_r <= valid_r[req.rd_addr];
        // RAM reads old data on a same-edge write: forward the new word
        byp_r   <= req.wr_en && (req.wr_addr == req.rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      byp_data_r <= wr_data;
    end
  end

  assign row_data = byp_r   ? byp_data_r :
                    vld_q_r ? ram_q      : '0;

endmodule

// File: sv/larb_lane_unit.sv
// Lane unit: fresh/reused row copies, write buffer and lane accumulation.
`timescale 1ns / 1ps
module larb_lane_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  larb_pkg::in_t                item,
  input  logic [larb_pkg::WORD_W-1:0]  row_data,
  output larb_pkg::out_t               result,
  output logic [larb_pkg::WORD_W-1:0]  buffer_word
);

  larb_pkg::lanes_t fresh_r, fresh_nxt;
  larb_pkg::lanes_t reused_r, reused_nxt;
  larb_pkg::lanes_t buf_r, buf_nxt;
  larb_pkg::lanes_t prev;
  larb_pkg::lanes_t acc_nxt;
  larb_pkg::lanes_t row_lanes;
  logic [larb_pkg::LANE_IW-1:0] lane_eff;
  logic [2*larb_pkg::LANE_W-1:0] wsum [larb_pkg::LANE_COUNT];
  logic [larb_pkg::LANE_W-1:0]   nsum [larb_pkg::LANE_COUNT];

  assign lane_eff  = larb_pkg::lane_mod(item.lane);
  assign row_lanes = larb_pkg::lanes_t'(row_data[larb_pkg::LANE_COUNT*larb_pkg::LANE_W-1:0]);

  always_comb begin
    if (item.first_slice) begin
      prev = '0;
    end else if (item.fresh_row_valid) begin
      prev = fresh_r;
    end else begin
      prev = reused_r;
    end
  end

  // Per lane: wide sum with this lane as high half, and narrow sum.
  for (genvar i = 0; i < larb_pkg::LANE_COUNT; i++) begin : g_lane
    localparam int LO    = (i + larb_pkg::LANE_COUNT - 1) % larb_pkg::LANE_COUNT;
    localparam int ABOVE = (i + 1) % larb_pkg::LANE_COUNT;

    assign wsum[i] = {prev[i], prev[LO]} + $unsigned(item.mac_value);
    assign nsum[i] = prev[i] + item.mac_value[larb_pkg::LANE_W-1:0];

    always_comb begin
      acc_nxt[i] = buf_r[i];
      if (item.wide_mode) begin
        if (lane_eff == larb_pkg::LANE_IW'(i)) begin
          acc_nxt[i] = wsum[i][2*larb_pkg::LANE_W-1:larb_pkg::LANE_W];
        end else if (lane_eff == larb_pkg::LANE_IW'(ABOVE)) begin
          acc_nxt[i] = wsum[ABOVE][larb_pkg::LANE_W-1:0];
        end
      end else if (lane_eff == larb_pkg::LANE_IW'(i)) begin
        acc_nxt[i] = nsum[i];
      end
    end
  end

  always_comb begin
    fresh_nxt  = fresh_r;
    reused_nxt = reused_r;
    buf_nxt    = buf_r;
    unique case (item.func)
      larb_pkg::FUNC_LATCH: begin
        fresh_nxt  = row_lanes;
        reused_nxt = row_lanes;
      end
      larb_pkg::FUNC_ACC: begin
        buf_nxt = acc_nxt;
      end
      default: begin
        // commit writes the store only; unused code holds all state
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r  <= '0;
      reused_r <= '0;
      buf_r    <= '0;
    end else if (fire) begin
      fresh_r  <= fresh_nxt;
      reused_r <= reused_nxt;
      buf_r    <= buf_nxt;
    end
  end

  assign result.row_word    = larb_pkg::pack_lanes(fresh_nxt);
  assign result.buffer_word = larb_pkg::pack_lanes(buf_nxt);
  assign buffer_word        = larb_pkg::pack_lanes(buf_r);

endmodule
